### design/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    // Fixed field widths of the bus and result channels
    localparam int unsigned AddrW    = 16;
    localparam int unsigned DataW    = 8;
    localparam int unsigned RomAddrW = 21;
    localparam int unsigned RamOffW  = 15;

    // Data returned for open bus and the RAM fill pattern
    localparam logic [DataW-1:0] OpenBus = 8'hFF;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ROM   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_ROM_SIZE  = 1'b0,
        CFG_RAM_BANKS = 1'b1
    } cfg_index_t;

    // Mapper register select, address bits 14:13 of a write below 0x8000
    typedef enum logic [1:0] {
        SEL_RAM_ENABLE = 2'd0,
        SEL_ROM_LOW    = 2'd1,
        SEL_BANK_HIGH  = 2'd2,
        SEL_MODE       = 2'd3
    } reg_sel_t;

    // Low nibble that enables cartridge RAM
    localparam logic [3:0] RamEnableKey = 4'hA;

    // Decoded access, passed from the mapper into the pipeline
    typedef struct packed {
        kind_t                 kind;
        logic [RomAddrW-1:0]   rom_address;
        logic                  ram_read;
        logic                  ram_write;
    } access_t;

endpackage

### design/cartridge_bank_mapper.sv
// Cartridge bank mapper top level: decode, RAM access and result pipeline.
// Pipeline: an accepted access is registered in stage 1 and then in the output register.
// Throughput: one access per cycle unless stalled, limited by the single RAM read port.
// Reset: mapper registers return to their defaults; the cartridge RAM is
// then filled with 0xFF by a sweep over all RAM_BYTES bytes, one byte a cycle,
// during which in_stall is high (configuration writes are still taken).
module cartridge_bank_mapper #(
    parameter int unsigned RAM_BYTES     = 32768,
    parameter int unsigned ROM_ADDR_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  cbm_pkg::cfg_index_t           cfg_index,
    input  logic [4:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [cbm_pkg::AddrW-1:0]     address,
    input  logic [cbm_pkg::DataW-1:0]     write_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    result_kind,
    output logic [cbm_pkg::RomAddrW-1:0]  rom_address,
    output logic [cbm_pkg::DataW-1:0]     read_data
);
    import cbm_pkg::*;

    localparam int unsigned RamAw = $clog2(RAM_BYTES);
    localparam logic [RamAw-1:0] ClrLast = RamAw'(RAM_BYTES - 1);

    logic             accept;
    logic             s2_load;
    logic             s1_adv;
    access_t          acc;
    logic [RamAw-1:0] ram_index;

    logic             clr_active_reg, clr_active_next;
    logic [RamAw-1:0] clr_addr_reg,   clr_addr_next;

    logic             ram_we;
    logic [RamAw-1:0] ram_waddr;
    logic [DataW-1:0] ram_wdata;
    logic             ram_re;
    logic [DataW-1:0] ram_q;

    logic             s1_valid_reg, s1_valid_next;
    access_t          s1_acc_reg;
    logic [DataW-1:0] s1_read_data;

    logic                out_valid_reg, out_valid_next;
    kind_t               kind_reg;
    logic [RomAddrW-1:0] rom_addr_reg;
    logic [DataW-1:0]    data_reg;

    // Flow control
    assign s2_load  = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && s2_load;
    assign in_stall = clr_active_reg || (s1_valid_reg && !s2_load);
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    cbm_mapper #(
        .RAM_BYTES     (RAM_BYTES),
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_mapper (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .acc        (acc),
        .ram_index  (ram_index)
    );

    // Fill sweep after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ClrLast)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // RAM ports: the sweep owns the write port until it is done
    assign ram_we    = clr_active_reg || (accept && acc.ram_write);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : ram_index;
    assign ram_wdata = clr_active_reg ? OpenBus : write_data;
    assign ram_re    = accept && acc.ram_read;

    cbm_ram #(
        .WIDTH (DataW),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_index),
        .rdata (ram_q)
    );

    // Stage 1: wait for RAM read data, hold while output is stalled
    assign s1_valid_next = accept || (s1_valid_reg && !s2_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_acc_reg <= acc;
        end
    end

    // Pick RAM byte, open bus or zero
    always_comb
    begin
        if (s1_acc_reg.ram_read)
        begin
            s1_read_data = ram_q;
        end
        else if (s1_acc_reg.kind == KIND_READ)
        begin
            s1_read_data = OpenBus;
        end
        else
        begin
            s1_read_data = '0;
        end
    end

    // Stage 2: output register
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            kind_reg     <= s1_acc_reg.kind;
            rom_addr_reg <= s1_acc_reg.rom_address;
            data_reg     <= s1_read_data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign rom_address = rom_addr_reg;
    assign read_data   = data_reg;

`ifndef ASSERT_OFF
    // No access enters while the fill sweep runs
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !accept)
        else $error("access accepted during RAM fill sweep");

    // An accepted access always lands in stage 1
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted access lost before stage 1");

    // A RAM read is only issued for a read access
    a_ram_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_acc_reg.ram_read |-> s1_acc_reg.kind == KIND_READ)
        else $error("RAM read tagged on non-read access");

    // The sweep ends only after the last RAM byte
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_addr_reg) == ClrLast)
        else $error("RAM fill sweep ended early");
`endif

endmodule

### design/cbm_ram.sv
// Generic simple dual-port RAM with registered read data.
module cbm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/cbm_mapper.sv
// Mapper and configuration registers with the bus access decoder.
module cbm_mapper #(
    parameter int unsigned RAM_BYTES     = 32768,
    parameter int unsigned ROM_ADDR_BITS = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  cbm_pkg::cfg_index_t          cfg_index,
    input  logic [4:0]                   cfg_data,
    input  logic                         accept,
    input  logic                         command,
    input  logic [cbm_pkg::AddrW-1:0]    address,
    input  logic [cbm_pkg::DataW-1:0]    write_data,
    output cbm_pkg::access_t             acc,
    output logic [$clog2(RAM_BYTES)-1:0] ram_index
);
    import cbm_pkg::*;

    localparam int unsigned RamAw    = $clog2(RAM_BYTES);
    localparam logic [RamOffW:0] RamLimit = (RamOffW+1)'(RAM_BYTES);

    logic [4:0] rom_size_reg;
    logic [2:0] ram_cnt_reg;
    logic       ram_en_reg,  ram_en_next;
    logic [6:0] rom_bnk_reg, rom_bnk_next;
    logic [1:0] ram_bnk_reg, ram_bnk_next;
    logic       mode_reg,    mode_next;

    logic                is_write;
    logic                in_ram_window;
    logic                ram_hit;
    logic [RamOffW-1:0]  ram_off;
    logic [RomAddrW-1:0] rom_mask;
    logic [RomAddrW-1:0] bank_addr;
    logic [6:0]          bank_low_set;
    logic [6:0]          bank_high_set;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg <= 5'd15;
            ram_cnt_reg  <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROM_SIZE:  rom_size_reg <= cfg_data;
                CFG_RAM_BANKS: ram_cnt_reg  <= cfg_data[2:0];
                default:       rom_size_reg <= rom_size_reg;
            endcase
        end
    end

    assign is_write = command;

    // Next values of the mapper registers on a write below 0x8000
    always_comb
    begin
        bank_low_set  = {rom_bnk_reg[6:5], write_data[4:0]};
        bank_high_set = {write_data[1:0], rom_bnk_reg[4:0]};
        ram_en_next   = ram_en_reg;
        rom_bnk_next  = rom_bnk_reg;
        ram_bnk_next  = ram_bnk_reg;
        mode_next     = mode_reg;
        if (accept && is_write && !address[15])
        begin
            case (reg_sel_t'(address[14:13]))
                SEL_RAM_ENABLE:
                begin
                    ram_en_next = (write_data[3:0] == RamEnableKey);
                end
                SEL_ROM_LOW:
                begin
                    rom_bnk_next = (bank_low_set == 7'd0) ? 7'd1 : bank_low_set;
                end
                SEL_BANK_HIGH:
                begin
                    if (mode_reg)
                    begin
                        ram_bnk_next = write_data[1:0];
                    end
                    else
                    begin
                        rom_bnk_next = (bank_high_set == 7'd0) ? 7'd1 : bank_high_set;
                    end
                end
                SEL_MODE:
                begin
                    mode_next = write_data[0];
                    if (!write_data[0])
                    begin
                        ram_bnk_next = 2'd0;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_en_reg  <= 1'b0;
            rom_bnk_reg <= 7'd1;
            ram_bnk_reg <= 2'd0;
            mode_reg    <= 1'b0;
        end
        else
        begin
            ram_en_reg  <= ram_en_next;
            rom_bnk_reg <= rom_bnk_next;
            ram_bnk_reg <= ram_bnk_next;
            mode_reg    <= mode_next;
        end
    end

    // Wrap mask for the switchable ROM window
    always_comb
    begin
        for (int i = 0; i < RomAddrW; i++)
        begin
            rom_mask[i] = (5'(i) < rom_size_reg) && (i < ROM_ADDR_BITS);
        end
    end

    assign bank_addr = {rom_bnk_reg, address[13:0]} & rom_mask;

    // Cartridge RAM reach
    assign in_ram_window = (address[15:13] == 3'b101);
    assign ram_off       = {ram_bnk_reg, address[12:0]};
    assign ram_hit       = in_ram_window && ram_en_reg
                        && ({1'b0, ram_bnk_reg} < ram_cnt_reg)
                        && ({1'b0, ram_off} < RamLimit);
    assign ram_index     = ram_off[RamAw-1:0];

    // Decode the access
    always_comb
    begin
        acc.rom_address = '0;
        acc.ram_read    = 1'b0;
        acc.ram_write   = 1'b0;
        if (is_write)
        begin
            acc.kind      = KIND_WRITE;
            acc.ram_write = ram_hit;
        end
        else if (address[15:14] == 2'b00)
        begin
            acc.kind        = KIND_ROM;
            acc.rom_address = RomAddrW'(address);
        end
        else if (!address[15])
        begin
            acc.kind        = KIND_ROM;
            acc.rom_address = bank_addr;
        end
        else
        begin
            acc.kind     = KIND_READ;
            acc.ram_read = ram_hit;
        end
    end

endmodule

### dv/cartridge_bank_mapper_tb.sv
// Self-checking testbench for the cartridge bank mapper: bus accesses, checked results.
module cartridge_bank_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int unsigned RamBytes    = 32768;
    localparam int unsigned RomAddrBits = 21;
    localparam int unsigned CycleLimit  = 600000;
    localparam int unsigned PhaseItems  = 165;
    localparam int unsigned NumPhases   = 7;
    localparam int unsigned MaxPrinted  = 40;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [AddrW-1:0] addr;
        logic [DataW-1:0] wdata;
    } bus_access_t;

    typedef struct packed {
        kind_t               kind;
        logic [RomAddrW-1:0] rom_addr;
        logic [DataW-1:0]    rdata;
    } bus_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index = CFG_ROM_SIZE;
    logic [4:0]           cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 command = CMD_READ;
    logic [AddrW-1:0]     address = '0;
    logic [DataW-1:0]     write_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           result_kind;
    logic [RomAddrW-1:0]  rom_address;
    logic [DataW-1:0]     read_data;

    // Accesses waiting to be offered and results waiting to arrive
    bus_access_t bus_queue[$];
    bus_result_t answers_due[$];

    // Mapper image: settings, registers and cartridge RAM
    logic [4:0]       rom_size_q;
    logic [2:0]       ram_cnt_q;
    logic             ram_on;
    logic [6:0]       rom_bnk;
    logic [1:0]       ram_bnk;
    logic             bank_mode;
    logic [DataW-1:0] ram_img [RamBytes];

    int unsigned items_pushed = 0;
    int unsigned items_taken  = 0;
    int unsigned errors       = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned n_rom = 0, n_ram_hit = 0, n_reg_wr = 0, n_open = 0;
    int unsigned holds_done   = 0;
    logic        in_took      = 1'b0;
    logic        jitter_on    = 1'b1;

    cartridge_bank_mapper #(
        .RAM_BYTES     (RamBytes),
        .ROM_ADDR_BITS (RomAddrBits)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .address     (address),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .rom_address (rom_address),
        .read_data   (read_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        if (errors < MaxPrinted)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Cartridge RAM slot reached by a RAM-window address, -1 when none
    function automatic int ram_slot(logic [AddrW-1:0] addr);
        int off;
        if (!ram_on || ram_cnt_q == 3'd0 || {1'b0, ram_bnk} >= ram_cnt_q)
            return -1;
        off = (int'(addr) - 'hA000) + int'(ram_bnk) * 'h2000;
        if (off >= int'(RamBytes))
            return -1;
        return off;
    endfunction

    // Update the mapper registers for a write below 0x8000
    task automatic set_mapper_reg(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
        reg_sel_t sel;
        sel = reg_sel_t'(addr[14:13]);
        case (sel)
            SEL_RAM_ENABLE: ram_on = (data[3:0] == RamEnableKey);
            SEL_ROM_LOW:
            begin
                rom_bnk = {rom_bnk[6:5], data[4:0]};
                if (rom_bnk == 7'd0)
                    rom_bnk = 7'd1;
            end
            SEL_BANK_HIGH:
            begin
                if (bank_mode)
                    ram_bnk = data[1:0];
                else
                begin
                    rom_bnk = {data[1:0], rom_bnk[4:0]};
                    if (rom_bnk == 7'd0)
                        rom_bnk = 7'd1;
                end
            end
            default:
            begin
                bank_mode = data[0];
                if (!bank_mode)
                    ram_bnk = 2'd0;
            end
        endcase
    endtask

    // Work out the result of one access and advance the mapper image
    task automatic map_access(input bus_access_t acc, output bus_result_t res);
        int          slot;
        int unsigned bits;
        logic [31:0] mask;
        logic [31:0] win;
        res = '{kind: KIND_ROM, rom_addr: '0, rdata: '0};
        slot = (acc.addr[15:13] == 3'b101) ? ram_slot(acc.addr) : -1;
        if (acc.cmd == CMD_WRITE)
        begin
            res.kind = KIND_WRITE;
            if (!acc.addr[15])
            begin
                set_mapper_reg(acc.addr, acc.wdata);
                n_reg_wr++;
            end
            else if (slot >= 0)
            begin
                ram_img[slot] = acc.wdata;
                n_ram_hit++;
            end
            else
                n_open++;
        end
        else if (acc.addr < 16'h4000)
        begin
            res.rom_addr = RomAddrW'(acc.addr);
            n_rom++;
        end
        else if (acc.addr < 16'h8000)
        begin
            bits = (rom_size_q > RomAddrBits) ? RomAddrBits : rom_size_q;
            mask = (32'd1 << bits) - 32'd1;
            win  = (32'(acc.addr) - 32'h4000) + 32'(rom_bnk) * 32'h4000;
            res.rom_addr = RomAddrW'(win & mask);
            n_rom++;
        end
        else
        begin
            res.kind  = KIND_READ;
            res.rdata = OpenBus;
            if (slot >= 0)
            begin
                res.rdata = ram_img[slot];
                n_ram_hit++;
            end
            else
                n_open++;
        end
    endtask

    // Predict on every accepted transfer, check every delivered result
    always @(posedge clk)
    begin
        bus_access_t acc;
        bus_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROM_SIZE)
                    rom_size_q = cfg_data;
                else
                    ram_cnt_q = cfg_data[2:0];
            end
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                    flag_mismatch("result with nothing outstanding", result_kind, 0);
                else
                begin
                    want = answers_due.pop_front();
                    if (result_kind !== want.kind)
                        flag_mismatch("result_kind", result_kind, want.kind);
                    if (rom_address !== want.rom_addr)
                        flag_mismatch("rom_address", rom_address, want.rom_addr);
                    if (read_data !== want.rdata)
                        flag_mismatch("read_data", read_data, want.rdata);
                end
            end
            if (in_valid && !in_stall)
            begin
                acc = '{cmd: command, addr: address, wdata: write_data};
                map_access(acc, want);
                answers_due.push_back(want);
                items_taken++;
            end
        end
        in_took <= rst_n && in_valid && !in_stall;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!jitter_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer queued accesses; hold the payload while stalled
    always @(negedge clk)
    begin
        bus_access_t nxt;
        static int unsigned gap_left = 0;
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (bus_queue.size() > 0)
            begin
                nxt = bus_queue.pop_front();
                command    <= nxt.cmd;
                address    <= nxt.addr;
                write_data <= nxt.wdata;
                in_valid   <= 1'b1;
                gap_left   = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Drive result backpressure; hold off for a long stretch twice
    always @(negedge clk)
    begin
        static int unsigned stall_left = 0;
        int unsigned r;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (holds_done < 2 && items_taken >= 300 + 550 * holds_done)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(250, 350);
            holds_done++;
        end
        else if (!jitter_on)
            out_stall <= 1'b0;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                out_stall <= 1'b0;
            else if (r < 92)
                out_stall <= 1'b1;
            else
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(7, 39);
            end
        end
    end

    // End the run if it stops making progress
    initial
    begin
        while (cycle_cnt < CycleLimit)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic push_access(logic cmd, logic [AddrW-1:0] addr, logic [DataW-1:0] wd);
        bus_queue.push_back('{cmd: cmd, addr: addr, wdata: wd});
        items_pushed++;
    endtask

    function automatic logic [AddrW-1:0] ram_window_addr();
        case ($urandom_range(0, 3))
            0: return 16'hA000 + 16'($urandom_range(0, 15));
            1: return 16'hBFF0 + 16'($urandom_range(0, 15));
            default: return 16'hA000 + 16'($urandom_range(0, 'h1FFF));
        endcase
    endfunction

    // Random traffic: bank setup bursts, register writes, ROM and RAM accesses, noise
    task automatic push_random();
        int unsigned      r;
        int unsigned      n;
        logic [AddrW-1:0] hot [8];
        logic [AddrW-1:0] a;
        logic [DataW-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            push_access(CMD_WRITE, 16'($urandom_range(0, 'h1FFF)), {4'($urandom), RamEnableKey});
            push_access(CMD_WRITE, 16'($urandom_range('h6000, 'h7FFF)), {7'($urandom), 1'b1});
            push_access(CMD_WRITE, 16'($urandom_range('h4000, 'h5FFF)), 8'($urandom));
            n = $urandom_range(2, 6);
            for (int i = 0; i < n; i++)
            begin
                hot[i] = ram_window_addr();
                push_access(CMD_WRITE, hot[i], 8'($urandom));
            end
            for (int i = 0; i < n; i++)
                push_access(CMD_READ, hot[i], 8'($urandom));
        end
        else if (r < 35)
        begin
            a = 16'($urandom_range(0, 'h7FFF));
            d = 8'($urandom);
            if (a[14:13] == SEL_RAM_ENABLE && $urandom_range(0, 9) < 6)
                d[3:0] = RamEnableKey;
            push_access(CMD_WRITE, a, d);
        end
        else if (r < 55)
            push_access(CMD_READ, 16'($urandom_range(0, 'h7FFF)), 8'($urandom));
        else if (r < 85)
            push_access(1'($urandom), ram_window_addr(), 8'($urandom));
        else
            push_access(1'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic write_setting(cfg_index_t idx, logic [4:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued access has been taken and answered
    task automatic wait_drained();
        while (items_taken != items_pushed || answers_due.size() != 0)
            @(negedge clk);
    endtask

    // Reset, then run a directed opening and random phases under several settings
    initial
    begin
        logic [4:0] rom_sizes [NumPhases];
        logic [4:0] bank_cnts [NumPhases];
        int unsigned target;
        rom_sizes = '{5'd21, 5'd15, 5'd18, 5'd13, 5'd20, 5'd23, 5'd16};
        bank_cnts = '{5'd4,  5'd0,  5'd2,  5'd7,  5'd1,  5'd5,  5'd3};

        rom_size_q  = 5'd15;
        ram_cnt_q   = 3'd0;
        ram_on      = 1'b0;
        rom_bnk     = 7'd1;
        ram_bnk     = 2'd0;
        bank_mode   = 1'b0;
        foreach (ram_img[i])
            ram_img[i] = OpenBus;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < NumPhases; p++)
        begin
            wait_drained();
            write_setting(CFG_ROM_SIZE, rom_sizes[p]);
            write_setting(CFG_RAM_BANKS, bank_cnts[p]);
            jitter_on = (p != 3);
            target = items_pushed + PhaseItems;
            if (p == 0)
            begin
                // Window edges, bank zero remap, RAM enable/bank/mode, unmapped space
                push_access(CMD_READ,  16'h0000, 8'h00);
                push_access(CMD_READ,  16'h3FFF, 8'hFF);
                push_access(CMD_READ,  16'h4000, 8'h00);
                push_access(CMD_WRITE, 16'h2000, 8'h00);
                push_access(CMD_READ,  16'h7FFF, 8'h00);
                push_access(CMD_WRITE, 16'h3FFF, 8'hFF);
                push_access(CMD_WRITE, 16'h4000, 8'h03);
                push_access(CMD_READ,  16'h7FFF, 8'h00);
                push_access(CMD_WRITE, 16'h2000, 8'h20);
                push_access(CMD_WRITE, 16'h5FFF, 8'h00);
                push_access(CMD_READ,  16'h4000, 8'h00);
                push_access(CMD_READ,  16'hA000, 8'h00);
                push_access(CMD_WRITE, 16'h0000, 8'h0A);
                push_access(CMD_WRITE, 16'hA000, 8'h5A);
                push_access(CMD_READ,  16'hA000, 8'h00);
                push_access(CMD_WRITE, 16'h6000, 8'h01);
                push_access(CMD_WRITE, 16'h4000, 8'h03);
                push_access(CMD_WRITE, 16'hBFFF, 8'h00);
                push_access(CMD_READ,  16'hBFFF, 8'h00);
                push_access(CMD_WRITE, 16'h7FFF, 8'hFE);
                push_access(CMD_READ,  16'hBFFF, 8'h00);
                push_access(CMD_READ,  16'h8000, 8'h00);
                push_access(CMD_READ,  16'hFFFF, 8'h00);
                push_access(CMD_WRITE, 16'hC000, 8'h12);
                push_access(CMD_WRITE, 16'h1FFF, 8'h0B);
                push_access(CMD_READ,  16'hA000, 8'h00);
            end
            while (items_pushed < target)
                push_random();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Covered %0d accesses under %0d mapper settings, %0d long receiver hold-offs",
                 items_taken, NumPhases, holds_done);
        $display("  %0d ROM fetches, %0d RAM hits, %0d register writes, %0d open-bus or dropped",
                 n_rom, n_ram_hit, n_reg_wr, n_open);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
